// ===== rtl/core/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// Depends on nothing; imported by lru_key_value_cache.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = IDX_W;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [RANK_W-1:0] rank;
  } entry_t;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key/value cache with LRU replacement.
// Depends on lkvc_pkg (entry layout, widths, codes).
// Usage:
//   Input channel (in_valid/in_ready) takes one item: func (get/put), key, value.
//   Output channel (out_valid/out_ready) returns one item per input: found,
//   read_value, evicted, evicted_key. Config channel (cfg_valid/cfg_ready)
//   writes the capacity register; write it only while the block is idle.
// Timing:
//   Keys, values and recency ranks live in one memory with a registered read.
//   An item runs a scan over all entries (key match, oldest entry, first free
//   slot), a decision step, a rank update sweep over all entries and a load
//   of the output register; the next item is taken only after that load, so
//   one item is processed at a time. A get miss skips the sweep.
// Reset:
//   Valid bits and the entry count clear at once, capacity returns to 16;
//   memory contents are not cleared and no clearing pass is needed.
// Stalls:
//   A finished result waits in the output register; the next item is taken
//   meanwhile and completes up to the point where it needs that register.
module lru_key_value_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [lkvc_pkg::DATA_W-1:0] key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
  output logic                          evicted,
  output logic signed [lkvc_pkg::DATA_W-1:0] evicted_key
);
  import lkvc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  state_t state;

  entry_t mem [ENTRIES];
  entry_t rd_data;
  entry_t wr_data;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;

  logic [CAP_W-1:0]   capacity;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   count;
  logic [IDX_W:0]     cnt;
  logic [IDX_W-1:0]   j;
  logic [CNT_W-1:0]   cap_eff;

  // item being processed
  logic              func_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] value_r;

  // scan results
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic [DATA_W-1:0] hit_value;
  logic              have_old;
  logic [IDX_W-1:0]  old_idx;
  logic [RANK_W-1:0] old_rank;
  logic [DATA_W-1:0] old_key;
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;

  // update sweep control and pending result
  logic              insert_mode;
  logic [IDX_W-1:0]  slot;
  logic [DATA_W-1:0] slot_value;
  logic              res_found;
  logic [DATA_W-1:0] res_value;
  logic              res_evicted;
  logic [DATA_W-1:0] res_key;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    j         = IDX_W'(cnt - 1'b1);
    mem_raddr = cnt[IDX_W-1:0];
    mem_waddr = j;
    wr_data   = rd_data;
    if (j == slot) begin
      wr_data.key   = key_r;
      wr_data.value = slot_value;
      wr_data.rank  = '0;
    end else if (insert_mode || (rd_data.rank < hit_rank)) begin
      // age every entry more recent than the touched one, or all on insert
      wr_data.rank = rd_data.rank + 1'b1;
    end
    mem_we = (state == ST_UPDATE) && (cnt != '0) && (valid[j] || (j == slot));

    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_data;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_RESET;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            func_r    <= func;
            key_r     <= key;
            value_r   <= value;
            hit       <= 1'b0;
            have_old  <= 1'b0;
            have_free <= 1'b0;
            cnt       <= '0;
            state     <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (cnt != '0) begin
            if (valid[j] && (rd_data.key == key_r) && !hit) begin
              hit       <= 1'b1;
              hit_idx   <= j;
              hit_rank  <= rd_data.rank;
              hit_value <= rd_data.value;
            end
            if (valid[j] && (!have_old || (rd_data.rank > old_rank))) begin
              have_old <= 1'b1;
              old_idx  <= j;
              old_rank <= rd_data.rank;
              old_key  <= rd_data.key;
            end
            if (!valid[j] && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= j;
            end
          end
          if (cnt == (IDX_W+1)'(ENTRIES)) begin
            state <= ST_DECIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_DECIDE: begin
          cnt         <= '0;
          res_found   <= hit;
          res_evicted <= 1'b0;
          res_key     <= '0;
          insert_mode <= 1'b0;
          slot        <= hit_idx;
          if (func_r == FUNC_GET) begin
            res_value  <= hit ? hit_value : MISS_VALUE;
            slot_value <= hit_value;
            state      <= hit ? ST_UPDATE : ST_DONE;
          end else begin
            res_value  <= '0;
            slot_value <= value_r;
            state      <= ST_UPDATE;
            if (!hit) begin
              insert_mode <= 1'b1;
              if (count >= cap_eff) begin
                // evict oldest and reuse its slot; count stays the same
                res_evicted <= 1'b1;
                res_key     <= old_key;
                slot        <= old_idx;
              end else begin
                slot         <= free_idx;
                valid[free_idx] <= 1'b1;
                count        <= count + 1'b1;
              end
            end
          end
        end

        ST_UPDATE: begin
          if (cnt == (IDX_W+1)'(ENTRIES)) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            found       <= res_found;
            read_value  <= res_value;
            evicted     <= res_evicted;
            evicted_key <= res_key;
            state       <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count exceeds number of entries");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid) == int'(count)))
    else $error("entry count disagrees with valid bits");

  a_no_evict_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(evicted && found))
    else $error("eviction reported on a hit");

  a_slot_valid_in_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> valid[slot])
    else $error("update sweep targets an invalid slot");
`endif

endmodule

// ===== dv/lru_key_value_cache_test.sv =====
`timescale 1ns / 100ps
// Self-checking test for the LRU key/value cache: a queue-fed driver, a monitor
// with its own cache model, random idling on both channels.
// Depends on lkvc_pkg and lru_key_value_cache.
module lru_key_value_cache_test;
  import lkvc_pkg::*;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } cache_op_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } cache_resp_t;

  localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] WORD_NEG1 = '1;
  localparam int OPS_PER_PHASE = 275;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_GET;
  logic [DATA_W-1:0] key = '0;
  logic [DATA_W-1:0] value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [DATA_W-1:0] read_value;
  logic              evicted;
  logic [DATA_W-1:0] evicted_key;

  lru_key_value_cache u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .read_value(read_value),
    .evicted(evicted),
    .evicted_key(evicted_key)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cache_op_t   pending_ops[$];
  cache_resp_t expected_resps[$];
  int          in_count = 0;
  int          out_count = 0;
  int          issued = 0;
  int          err_count = 0;
  bit          quiet = 1'b0;

  // Cache model: slot contents, live bits, recency (0 = newest), fill count.
  logic [DATA_W-1:0] slot_key[ENTRIES];
  logic [DATA_W-1:0] slot_val[ENTRIES];
  bit                slot_live[ENTRIES];
  int unsigned       slot_age[ENTRIES];
  int unsigned       live_count = 0;
  logic [CAP_W-1:0]  cur_capacity = CAP_RESET;

  function automatic void make_newest(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic cache_resp_t cache_access(cache_op_t op);
    cache_resp_t r;
    int hit;
    int slot;
    int oldest;
    int unsigned lim;
    r = '0;
    hit = -1;
    slot = -1;
    oldest = -1;
    lim = (cur_capacity == 0) ? 1 : (cur_capacity > ENTRIES) ? ENTRIES : cur_capacity;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == op.key) hit = i;
    if (op.func == FUNC_GET) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.read_value = slot_val[hit];
        make_newest(hit);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (hit >= 0) begin
      r.found = 1'b1;
      slot_val[hit] = op.value;
      make_newest(hit);
    end else begin
      // Full (or over a lowered capacity): drop the oldest entry and reuse its slot.
      if (live_count >= lim) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
        if (oldest >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[oldest];
          slot_live[oldest] = 1'b0;
          live_count--;
          slot = oldest;
        end
      end
      if (slot < 0)
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_live[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_key[slot] = op.key;
        slot_val[slot] = op.value;
        slot_live[slot] = 1'b1;
        slot_age[slot] = 0;
        live_count++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    err_count++;
    if (err_count <= 40)
      $display("%0t: result %0d %s: got %h, want %h", $time, out_count, what, got, want);
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  // Monitor: check results first, then predict the item taken at this edge.
  always @(posedge clk) begin : monitor
    cache_resp_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("with no item outstanding", read_value, '0);
        end else begin
          want = expected_resps.pop_front();
          if (found !== want.found)
            report_mismatch("found", DATA_W'(found), DATA_W'(want.found));
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
          if (evicted !== want.evicted)
            report_mismatch("evicted", DATA_W'(evicted), DATA_W'(want.evicted));
          if (evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", evicted_key, want.evicted_key);
        end
        out_count++;
      end
      if (in_valid && in_ready) begin
        expected_resps.push_back(cache_access(cache_op_t'{func, key, value}));
        in_count++;
      end
      if (cfg_valid && cfg_ready) cur_capacity = cfg_data;
    end
  end

  int send_idle_pct = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    cache_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_count != issued)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0 && !quiet && send_idle_pct != 0 &&
                   $urandom_range(99) < send_idle_pct) begin
        gap_left = $urandom_range(15, 0);
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        func <= op.func;
        key <= op.key;
        value <= op.value;
        in_valid <= 1'b1;
        issued++;
        if (issued % 40 == 0) send_idle_pct = pick_idle_pct();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int recv_stall_pct = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int next_reroll = 40;

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      // Hold off once for a long stretch so the input side backs up.
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (out_count >= next_reroll) begin
        next_reroll += 40;
        recv_stall_pct = pick_idle_pct();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
        stall_left = $urandom_range(15, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_op(logic f, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
    pending_ops.push_back(cache_op_t'{f, k, v});
  endfunction

  // Draw keys mostly from a small pool sized near the capacity so hits and
  // evictions both happen; some fresh keys give misses and full bit coverage.
  function automatic void add_random_ops(int n, int cap);
    logic [DATA_W-1:0] pool[24];
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    int pool_n;
    pool[0] = '0;
    pool[1] = WORD_NEG1;
    pool[2] = WORD_MIN;
    pool[3] = WORD_MAX;
    for (int i = 4; i < 24; i++) pool[i] = $urandom;
    pool_n = cap + $urandom_range(6, 2);
    if (pool_n > 24) pool_n = 24;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(pool_n - 1)];
      case ($urandom_range(19))
        0: v = WORD_MIN;
        1: v = WORD_MAX;
        2: v = WORD_NEG1;
        3: v = '0;
        default: v = $urandom;
      endcase
      queue_op($urandom_range(1) ? FUNC_PUT : FUNC_GET, k, v);
    end
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_count != issued || expected_resps.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int caps[7];
    caps = '{1, 16, 8, 2, 13, 5, 16};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes, get miss on an empty cache, put hit, then fill and evict.
    queue_op(FUNC_GET, '0, '0);
    queue_op(FUNC_PUT, WORD_MIN, WORD_MAX);
    queue_op(FUNC_PUT, WORD_MAX, WORD_MIN);
    queue_op(FUNC_PUT, '0, '0);
    queue_op(FUNC_PUT, WORD_NEG1, WORD_NEG1);
    queue_op(FUNC_GET, WORD_MIN, '0);
    queue_op(FUNC_PUT, WORD_MAX, 32'd5);
    queue_op(FUNC_GET, WORD_MAX, WORD_NEG1);
    queue_op(FUNC_GET, 32'd12345, '0);
    for (int i = 0; i < 12; i++) queue_op(FUNC_PUT, 32'd100 + i, $urandom);
    queue_op(FUNC_PUT, 32'd200, 32'd7);
    wait_idle();

    // Lower capacity under the fill count: each put miss evicts exactly one.
    write_capacity(CAP_W'(2));
    queue_op(FUNC_PUT, 32'd300, $urandom);
    queue_op(FUNC_PUT, 32'd301, $urandom);
    queue_op(FUNC_GET, 32'd200, '0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) quiet = 1'b1;
      write_capacity(CAP_W'(caps[p]));
      add_random_ops(OPS_PER_PHASE, caps[p]);
      wait_idle();
    end

    repeat (80) @(posedge clk);
    if (expected_resps.size() != 0)
      report_mismatch("left outstanding", DATA_W'(expected_resps.size()), '0);
    if (err_count == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("FAIL lru_key_value_cache");
    $finish;
  end

endmodule
